// ===== rtl/ps2a_pkg.sv =====
// shared types, scan code constants and translation tables for the ps2 scan code decoder
// no dependencies; used by ps2a_decode and ps2_scancode_to_ascii_core
`default_nettype none

package ps2a_pkg;

    typedef enum logic [1:0] {
        PH_NONE      = 2'd0,
        PH_E0        = 2'd1,
        PH_E1        = 2'd2,
        PH_PAUSE_MID = 2'd3
    } ps2a_phase_t;

    // mods: 0 lshift, 1 rshift, 2 lctrl, 3 rctrl, 4 lalt, 5 ralt
    // locks and held: 0 num, 1 caps, 2 scroll
    typedef struct packed {
        ps2a_phase_t phase;
        logic [5:0]  mods;
        logic [2:0]  locks;
        logic [2:0]  held;
    } ps2a_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       break_request;
        logic       num_lock_on;
        logic       caps_lock_on;
        logic       scroll_lock_on;
    } ps2a_result_t;

    localparam logic [7:0] ScPrefixE0 = 8'hE0;
    localparam logic [7:0] ScPrefixE1 = 8'hE1;
    localparam logic [7:0] ScCtrl     = 8'h1D;
    localparam logic [7:0] ScLshift   = 8'h2A;
    localparam logic [7:0] ScRshift   = 8'h36;
    localparam logic [7:0] ScAlt      = 8'h38;
    localparam logic [7:0] ScCaps     = 8'h3A;
    localparam logic [7:0] ScNum      = 8'h45;
    localparam logic [7:0] ScScroll   = 8'h46;
    localparam logic [7:0] ScBrkBit   = 8'h80;
    localparam logic [7:0] ScCtrlBrk  = ScCtrl | ScBrkBit;
    localparam logic [7:0] ScLshiftBrk = ScLshift | ScBrkBit;
    localparam logic [7:0] ScRshiftBrk = ScRshift | ScBrkBit;
    localparam logic [7:0] ScAltBrk   = ScAlt | ScBrkBit;
    localparam logic [7:0] ScCapsBrk  = ScCaps | ScBrkBit;
    localparam logic [7:0] ScNumBrk   = ScNum | ScBrkBit;
    localparam logic [7:0] ScScrollBrk = ScScroll | ScBrkBit;
    localparam logic [7:0] ScTableEnd = 8'h58;
    localparam logic [6:0] PauseChar  = 7'h05;

    localparam logic [6:0] ChLowerA = 7'h61;
    localparam logic [6:0] ChLowerC = 7'h63;
    localparam logic [6:0] ChLowerZ = 7'h7A;

    localparam int ModLshift = 0;
    localparam int ModRshift = 1;
    localparam int ModLctrl  = 2;
    localparam int ModRctrl  = 3;
    localparam int ModLalt   = 4;
    localparam int ModRalt   = 5;

    localparam int LockNum    = 0;
    localparam int LockCaps   = 1;
    localparam int LockScroll = 2;

    function automatic logic [6:0] plain_map(input logic [6:0] idx);
        logic [6:0] ch;
        case (idx)
            7'd1:  ch = 7'h1B;
            7'd2:  ch = 7'h31;
            7'd3:  ch = 7'h32;
            7'd4:  ch = 7'h33;
            7'd5:  ch = 7'h34;
            7'd6:  ch = 7'h35;
            7'd7:  ch = 7'h36;
            7'd8:  ch = 7'h37;
            7'd9:  ch = 7'h38;
            7'd10: ch = 7'h39;
            7'd11: ch = 7'h30;
            7'd12: ch = 7'h2D;
            7'd13: ch = 7'h3D;
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = 7'h71;
            7'd17: ch = 7'h77;
            7'd18: ch = 7'h65;
            7'd19: ch = 7'h72;
            7'd20: ch = 7'h74;
            7'd21: ch = 7'h79;
            7'd22: ch = 7'h75;
            7'd23: ch = 7'h69;
            7'd24: ch = 7'h6F;
            7'd25: ch = 7'h70;
            7'd26: ch = 7'h5B;
            7'd27: ch = 7'h5D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h61;
            7'd31: ch = 7'h73;
            7'd32: ch = 7'h64;
            7'd33: ch = 7'h66;
            7'd34: ch = 7'h67;
            7'd35: ch = 7'h68;
            7'd36: ch = 7'h6A;
            7'd37: ch = 7'h6B;
            7'd38: ch = 7'h6C;
            7'd39: ch = 7'h3B;
            7'd40: ch = 7'h27;
            7'd41: ch = 7'h60;
            7'd43: ch = 7'h5C;
            7'd44: ch = 7'h7A;
            7'd45: ch = 7'h78;
            7'd46: ch = 7'h63;
            7'd47: ch = 7'h76;
            7'd48: ch = 7'h62;
            7'd49: ch = 7'h6E;
            7'd50: ch = 7'h6D;
            7'd51: ch = 7'h2C;
            7'd52: ch = 7'h2E;
            7'd53: ch = 7'h2F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            7'd71: ch = 7'h37;
            7'd72: ch = 7'h38;
            7'd73: ch = 7'h39;
            7'd74: ch = 7'h2D;
            7'd75: ch = 7'h34;
            7'd76: ch = 7'h35;
            7'd77: ch = 7'h36;
            7'd78: ch = 7'h2B;
            7'd79: ch = 7'h31;
            7'd80: ch = 7'h32;
            7'd81: ch = 7'h33;
            7'd82: ch = 7'h30;
            7'd83: ch = 7'h2E;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] shift_map(input logic [6:0] idx);
        logic [6:0] ch;
        case (idx)
            7'd1:  ch = 7'h1B;
            7'd2:  ch = 7'h21;
            7'd3:  ch = 7'h40;
            7'd4:  ch = 7'h23;
            7'd5:  ch = 7'h24;
            7'd6:  ch = 7'h25;
            7'd7:  ch = 7'h5E;
            7'd8:  ch = 7'h26;
            7'd9:  ch = 7'h2A;
            7'd10: ch = 7'h28;
            7'd11: ch = 7'h29;
            7'd12: ch = 7'h5F;
            7'd13: ch = 7'h2B;
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = 7'h71;
            7'd17: ch = 7'h77;
            7'd18: ch = 7'h65;
            7'd19: ch = 7'h72;
            7'd20: ch = 7'h74;
            7'd21: ch = 7'h79;
            7'd22: ch = 7'h75;
            7'd23: ch = 7'h69;
            7'd24: ch = 7'h6F;
            7'd25: ch = 7'h70;
            7'd26: ch = 7'h7B;
            7'd27: ch = 7'h7D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h61;
            7'd31: ch = 7'h73;
            7'd32: ch = 7'h64;
            7'd33: ch = 7'h66;
            7'd34: ch = 7'h67;
            7'd35: ch = 7'h68;
            7'd36: ch = 7'h6A;
            7'd37: ch = 7'h6B;
            7'd38: ch = 7'h6C;
            7'd39: ch = 7'h3A;
            7'd40: ch = 7'h22;
            7'd41: ch = 7'h7E;
            7'd43: ch = 7'h7C;
            7'd44: ch = 7'h7A;
            7'd45: ch = 7'h78;
            7'd46: ch = 7'h63;
            7'd47: ch = 7'h76;
            7'd48: ch = 7'h62;
            7'd49: ch = 7'h6E;
            7'd50: ch = 7'h6D;
            7'd51: ch = 7'h3C;
            7'd52: ch = 7'h3E;
            7'd53: ch = 7'h3F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            7'd74: ch = 7'h2D;
            7'd78: ch = 7'h2B;
            7'd83: ch = 7'h7F;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2a_scan_if.sv =====
// valid/ready channel carrying one raw scan code byte per beat
// no dependencies
`default_nettype none

interface ps2a_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ps2a_key_if.sv =====
// valid/ready channel carrying one decoded character and lock status per beat
// no dependencies
`default_nettype none

interface ps2a_key_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [6:0] char_code;
    logic       break_request;
    logic       num_lock_on;
    logic       caps_lock_on;
    logic       scroll_lock_on;

    modport source (
        output valid, output char_valid, output char_code, output break_request,
        output num_lock_on, output caps_lock_on, output scroll_lock_on,
        input ready
    );
    modport sink (
        input valid, input char_valid, input char_code, input break_request,
        input num_lock_on, input caps_lock_on, input scroll_lock_on,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ps2a_decode.sv =====
// combinational decode of one scan byte: prefix tracking, modifiers, locks, translation
// depends on ps2a_pkg
`default_nettype none

module ps2a_decode
    import ps2a_pkg::*;
(
    input  wire logic [7:0]   scan_byte,
    input  wire ps2a_state_t  state,
    output ps2a_state_t       state_next,
    output ps2a_result_t      result
);

    logic       do_handle;
    logic       ext;
    logic       shift;
    logic       ctrl;
    logic       upper;
    logic       num_plain;
    logic       brk;
    logic [6:0] ch;
    logic [6:0] lut;
    logic [6:0] idx;
    logic [2:0] locks_n;

    assign shift = state.mods[ModLshift] | state.mods[ModRshift];
    assign ctrl  = state.mods[ModLctrl] | state.mods[ModRctrl];
    assign upper = state.locks[LockCaps] ^ shift;
    assign num_plain = state.locks[LockNum] ^ shift;
    assign idx = scan_byte[6:0];

    always_comb
    begin
        state_next = state;
        do_handle  = 1'b0;
        ext        = 1'b0;
        ch         = 7'h00;
        brk        = 1'b0;
        lut        = 7'h00;

        unique case (state.phase)
            PH_NONE:
            begin
                if (scan_byte == ScPrefixE0)
                begin
                    state_next.phase = PH_E0;
                end
                else if (scan_byte == ScPrefixE1)
                begin
                    state_next.phase = PH_E1;
                end
                else
                begin
                    do_handle = 1'b1;
                end
            end
            PH_E0:
            begin
                state_next.phase = PH_NONE;
                do_handle = 1'b1;
                ext = 1'b1;
            end
            PH_E1:
            begin
                state_next.phase = (scan_byte == ScCtrl || scan_byte == ScCtrlBrk)
                                   ? PH_PAUSE_MID : PH_NONE;
            end
            PH_PAUSE_MID:
            begin
                state_next.phase = PH_NONE;
                if (scan_byte == ScNum)
                begin
                    ch = PauseChar;
                end
            end
            default:
            begin
                state_next.phase = PH_NONE;
            end
        endcase

        if (do_handle)
        begin
            unique case (scan_byte)
                ScAlt:       state_next.mods[ext ? ModRalt : ModLalt] = 1'b1;
                ScCtrl:      state_next.mods[ext ? ModRctrl : ModLctrl] = 1'b1;
                ScLshift:    state_next.mods[ModLshift] = 1'b1;
                ScRshift:    state_next.mods[ModRshift] = 1'b1;
                ScAltBrk:    state_next.mods[ext ? ModRalt : ModLalt] = 1'b0;
                ScCtrlBrk:   state_next.mods[ext ? ModRctrl : ModLctrl] = 1'b0;
                ScLshiftBrk: state_next.mods[ModLshift] = 1'b0;
                ScRshiftBrk: state_next.mods[ModRshift] = 1'b0;
                ScNum, ScCaps, ScScroll:
                begin
                    // lock toggles only on a fresh press, not on auto-repeat
                    state_next.locks = state.locks ^ (locks_n & ~state.held);
                    state_next.held  = state.held | locks_n;
                end
                ScNumBrk:    state_next.held[LockNum] = 1'b0;
                ScCapsBrk:   state_next.held[LockCaps] = 1'b0;
                ScScrollBrk: state_next.held[LockScroll] = 1'b0;
                default:
                begin
                    if (scan_byte < ScNum)
                    begin
                        lut = shift ? shift_map(idx) : plain_map(idx);
                        ch = lut;
                        if (lut >= ChLowerA && lut <= ChLowerZ)
                        begin
                            if (ctrl)
                            begin
                                if (lut == ChLowerC)
                                begin
                                    ch  = 7'h00;
                                    brk = 1'b1;
                                end
                                else
                                begin
                                    ch = lut - 7'h60;
                                end
                            end
                            else if (upper)
                            begin
                                ch = lut - 7'h20;
                            end
                        end
                    end
                    else if (scan_byte < ScTableEnd)
                    begin
                        // extended keys always take the navigation meaning
                        ch = (!ext && num_plain) ? plain_map(idx) : shift_map(idx);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        locks_n = 3'b000;
        case (scan_byte)
            ScNum:    locks_n[LockNum] = 1'b1;
            ScCaps:   locks_n[LockCaps] = 1'b1;
            ScScroll: locks_n[LockScroll] = 1'b1;
            default:  locks_n = 3'b000;
        endcase
    end

    always_comb
    begin
        result.char_valid     = (ch != 7'h00);
        result.char_code      = ch;
        result.break_request  = brk;
        result.num_lock_on    = state_next.locks[LockNum];
        result.caps_lock_on   = state_next.locks[LockCaps];
        result.scroll_lock_on = state_next.locks[LockScroll];
    end

endmodule

`default_nettype wire

// ===== rtl/ps2_scancode_to_ascii_core.sv =====
// top level of the scan code set 1 to ascii decoder: input register, decode, result register
// depends on ps2a_pkg, ps2a_scan_if, ps2a_key_if, ps2a_decode
//
//   channel | dir  | beat contents
//   --------+------+----------------------------------------------------------
//   scan    | sink | scan_byte: one raw set 1 byte
//   key     | src  | char_valid, char_code, break_request, three lock states
//
// one beat per cycle sustained while key is ready; each byte passes through the input register,
// then decode into the result register
// every scan beat gives exactly one key beat, also for prefix and break bytes
// reset clears both valid flags, the prefix phase, modifiers and lock flags
// a stalled key beat holds; scan stays ready while the input register can drain
`default_nettype none

module ps2_scancode_to_ascii_core
    import ps2a_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ps2a_scan_if.sink     scan,
    ps2a_key_if.source    key
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    ps2a_result_t result_reg;
    ps2a_result_t result_next;
    ps2a_state_t  state_reg;
    ps2a_state_t  state_next;
    logic         advance;

    // decode moves a byte into the result register when that register is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || key.ready);
    assign scan.ready = !in_valid_reg || advance;

    ps2a_decode u_decode (
        .scan_byte  (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_NONE, mods: 6'b0, locks: 3'b0, held: 3'b0};
        end
        else
        begin
            if (scan.ready)
            begin
                in_valid_reg <= scan.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (key.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            in_byte_reg <= scan.scan_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign key.valid          = out_valid_reg;
    assign key.char_valid     = result_reg.char_valid;
    assign key.char_code      = result_reg.char_code;
    assign key.break_request  = result_reg.break_request;
    assign key.num_lock_on    = result_reg.num_lock_on;
    assign key.caps_lock_on   = result_reg.caps_lock_on;
    assign key.scroll_lock_on = result_reg.scroll_lock_on;

    // ctrl+c gives a break request in place of a character
    a_break_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && key.break_request |-> !key.char_valid)
        else $error("break request carries a character");

    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid |-> (key.char_valid == (key.char_code != 7'h00)))
        else $error("char_valid disagrees with char_code");

    // decoder state moves only when a byte is decoded
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("decoder state changed without a decoded byte");

    // lock outputs follow the lock flags left by the decoded byte
    a_locks_follow: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (key.num_lock_on == state_reg.locks[LockNum]
                     && key.caps_lock_on == state_reg.locks[LockCaps]
                     && key.scroll_lock_on == state_reg.locks[LockScroll]))
        else $error("lock outputs out of step with lock flags");

endmodule

`default_nettype wire
